// ===== design/isots_pkg.sv =====
// Shared constants and types for the ISO 8601 timestamp parser.
package isots_pkg;

   localparam int PhaseWidth = 5;

   localparam logic [PhaseWidth-1:0] PH_LEAD       = 5'd0;
   localparam logic [PhaseWidth-1:0] PH_Y2         = 5'd1;
   localparam logic [PhaseWidth-1:0] PH_Y3         = 5'd2;
   localparam logic [PhaseWidth-1:0] PH_Y4         = 5'd3;
   localparam logic [PhaseWidth-1:0] PH_DASH1      = 5'd4;
   localparam logic [PhaseWidth-1:0] PH_MO1        = 5'd5;
   localparam logic [PhaseWidth-1:0] PH_MO2        = 5'd6;
   localparam logic [PhaseWidth-1:0] PH_DASH2      = 5'd7;
   localparam logic [PhaseWidth-1:0] PH_D1         = 5'd8;
   localparam logic [PhaseWidth-1:0] PH_D2         = 5'd9;
   localparam logic [PhaseWidth-1:0] PH_AFTER_DATE = 5'd10;
   localparam logic [PhaseWidth-1:0] PH_SPACE      = 5'd11;
   localparam logic [PhaseWidth-1:0] PH_H1         = 5'd12;
   localparam logic [PhaseWidth-1:0] PH_H2         = 5'd13;
   localparam logic [PhaseWidth-1:0] PH_COLON1     = 5'd14;
   localparam logic [PhaseWidth-1:0] PH_MI1        = 5'd15;
   localparam logic [PhaseWidth-1:0] PH_MI2        = 5'd16;
   localparam logic [PhaseWidth-1:0] PH_AFTER_MIN  = 5'd17;
   localparam logic [PhaseWidth-1:0] PH_S1         = 5'd18;
   localparam logic [PhaseWidth-1:0] PH_S2         = 5'd19;
   localparam logic [PhaseWidth-1:0] PH_AFTER_SEC  = 5'd20;
   localparam logic [PhaseWidth-1:0] PH_FRAC0      = 5'd21;
   localparam logic [PhaseWidth-1:0] PH_FRAC       = 5'd22;
   localparam logic [PhaseWidth-1:0] PH_AFTER_ZONE = 5'd23;
   localparam logic [PhaseWidth-1:0] PH_OH1        = 5'd24;
   localparam logic [PhaseWidth-1:0] PH_OH2        = 5'd25;
   localparam logic [PhaseWidth-1:0] PH_AFTER_OH   = 5'd26;
   localparam logic [PhaseWidth-1:0] PH_OM1        = 5'd27;
   localparam logic [PhaseWidth-1:0] PH_OM2        = 5'd28;
   localparam logic [PhaseWidth-1:0] PH_TRAIL      = 5'd29;

   localparam logic [7:0] CH_T     = 8'd84;
   localparam logic [7:0] CH_Z     = 8'd90;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_ZERO  = 8'd48;

   // Datapath operation selects for the final conversion.
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_DATE  = 3'd1;
   localparam logic [2:0] OP_DAYS  = 3'd2;
   localparam logic [2:0] OP_TIME  = 3'd3;
   localparam logic [2:0] OP_SUM   = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   typedef struct packed {
      logic       char_en;
      logic [7:0] char_code;
      logic [2:0] op;
   } isots_cmd_type;

   typedef struct packed {
      logic fail;
      logic can_end;
   } isots_sts_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'd48) && (c <= 8'd57);
   endfunction

endpackage

// ===== design/isots_ctrl.sv =====
// Controller: handshake sequencing of character intake and final conversion.
module isots_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_code,
   input  logic                    req_is_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output isots_pkg::isots_cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DATE = 3'd1;
   localparam logic [2:0] S_DAYS = 3'd2;
   localparam logic [2:0] S_TIME = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.char_en   = take;
      cmd.char_code = req_char_code;
      cmd.op        = isots_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: if (take && req_is_last) state_in = S_DATE;
         S_DATE: begin
            cmd.op   = isots_pkg::OP_DATE;
            state_in = S_DAYS;
         end
         S_DAYS: begin
            cmd.op   = isots_pkg::OP_DAYS;
            state_in = S_TIME;
         end
         S_TIME: begin
            cmd.op   = isots_pkg::OP_TIME;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = isots_pkg::OP_SUM;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) begin
            cmd.op   = isots_pkg::OP_CLEAR;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ===== design/isots_dp.sv =====
// Datapath: field registers, character parsing and epoch conversion.
module isots_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  isots_pkg::isots_cmd_type  cmd,
   output isots_pkg::isots_sts_type  sts,
   output logic                     rsp_parse_ok,
   output logic signed [48:0]       rsp_epoch_millis
);
   logic [4:0]  phase_ff, phase_in;
   logic        failed_ff, failed_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [9:0]  millis_ff, millis_in;
   logic [1:0]  fcount_ff, fcount_in;
   logic        fnz_ff, fnz_in;
   logic        zneg_ff, zneg_in;
   logic [6:0]  zh_ff, zh_in;
   logic [6:0]  zm_ff, zm_in;

   logic        ok_ff;
   logic signed [48:0] acc_ff;
   logic signed [22:0] days_ff;
   logic signed [5:0]  era_ff;
   logic [8:0]  yoe_ff;
   logic [8:0]  doy_ff;

   logic [7:0] c;
   logic [3:0] d;
   logic       dig, ws;

   assign c   = cmd.char_code;
   assign d   = 4'(c - isots_pkg::CH_ZERO);
   assign dig = isots_pkg::is_dig(c);
   assign ws  = isots_pkg::is_ws(c);

   function automatic logic [13:0] mac14(input logic [13:0] a, input logic [3:0] x);
      return 14'(a * 14'd10 + 14'(x));
   endfunction
   function automatic logic [6:0] mac7(input logic [6:0] a, input logic [3:0] x);
      return 7'(a * 7'd10 + 7'(x));
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      failed_in = failed_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      millis_in = millis_ff;
      fcount_in = fcount_ff;
      fnz_in    = fnz_ff;
      zneg_in   = zneg_ff;
      zh_in     = zh_ff;
      zm_in     = zm_ff;
      if (cmd.char_en && !failed_ff) begin
         unique case (phase_ff) inside
            isots_pkg::PH_LEAD, isots_pkg::PH_Y2, isots_pkg::PH_Y3, isots_pkg::PH_Y4: begin
               if (phase_ff == isots_pkg::PH_LEAD && ws) begin
                  phase_in = phase_ff;
               end else if (dig) begin
                  year_in  = mac14(year_ff, d);
                  phase_in = 5'(phase_ff + 5'd1);
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_DASH1, isots_pkg::PH_DASH2: begin
               if (c == isots_pkg::CH_MINUS) phase_in = 5'(phase_ff + 5'd1);
               else failed_in = 1'b1;
            end
            isots_pkg::PH_MO1, isots_pkg::PH_MO2: begin
               if (dig) begin
                  month_in = mac7(month_ff, d);
                  phase_in = 5'(phase_ff + 5'd1);
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_D1, isots_pkg::PH_D2: begin
               if (dig) begin
                  day_in   = mac7(day_ff, d);
                  phase_in = 5'(phase_ff + 5'd1);
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_AFTER_DATE: begin
               if (c == isots_pkg::CH_T)          phase_in = isots_pkg::PH_H1;
               else if (c == isots_pkg::CH_SPACE) phase_in = isots_pkg::PH_SPACE;
               else if (ws)                        phase_in = isots_pkg::PH_TRAIL;
               else                                failed_in = 1'b1;
            end
            isots_pkg::PH_SPACE, isots_pkg::PH_H1, isots_pkg::PH_H2: begin
               if (dig) begin
                  hour_in  = mac7(hour_ff, d);
                  phase_in = (phase_ff == isots_pkg::PH_H2) ? isots_pkg::PH_COLON1
                                                             : isots_pkg::PH_H2;
               end else if (phase_ff == isots_pkg::PH_SPACE && ws) begin
                  phase_in = isots_pkg::PH_TRAIL;
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_COLON1: begin
               if (c == isots_pkg::CH_COLON) phase_in = isots_pkg::PH_MI1;
               else failed_in = 1'b1;
            end
            isots_pkg::PH_MI1, isots_pkg::PH_MI2: begin
               if (dig) begin
                  minute_in = mac7(minute_ff, d);
                  phase_in  = 5'(phase_ff + 5'd1);
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_S1, isots_pkg::PH_S2: begin
               if (dig) begin
                  second_in = mac7(second_ff, d);
                  phase_in  = 5'(phase_ff + 5'd1);
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_FRAC0: begin
               if (dig) begin
                  if (fcount_ff != 2'd3) begin
                     millis_in = 10'(millis_ff * 10'd10 + 10'(d));
                     fcount_in = 2'(fcount_ff + 2'd1);
                  end
                  if (d != 4'd0) fnz_in = 1'b1;
                  phase_in = isots_pkg::PH_FRAC;
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_AFTER_MIN, isots_pkg::PH_AFTER_SEC, isots_pkg::PH_FRAC: begin
               if (phase_ff == isots_pkg::PH_AFTER_MIN && c == isots_pkg::CH_COLON) begin
                  phase_in = isots_pkg::PH_S1;
               end else if (phase_ff == isots_pkg::PH_AFTER_SEC &&
                            (c == isots_pkg::CH_DOT || c == isots_pkg::CH_COMMA)) begin
                  phase_in = isots_pkg::PH_FRAC0;
               end else if (phase_ff == isots_pkg::PH_FRAC && dig) begin
                  if (fcount_ff != 2'd3) begin
                     millis_in = 10'(millis_ff * 10'd10 + 10'(d));
                     fcount_in = 2'(fcount_ff + 2'd1);
                  end
                  if (d != 4'd0) fnz_in = 1'b1;
               end else if (c == isots_pkg::CH_Z) begin
                  phase_in = isots_pkg::PH_AFTER_ZONE;
               end else if (c == isots_pkg::CH_PLUS || c == isots_pkg::CH_MINUS) begin
                  zneg_in  = (c == isots_pkg::CH_MINUS);
                  phase_in = isots_pkg::PH_OH1;
               end else if (ws) begin
                  phase_in = isots_pkg::PH_TRAIL;
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_AFTER_ZONE, isots_pkg::PH_TRAIL: begin
               if (ws) phase_in = isots_pkg::PH_TRAIL;
               else failed_in = 1'b1;
            end
            isots_pkg::PH_OH1, isots_pkg::PH_OH2: begin
               if (dig) begin
                  zh_in    = mac7(zh_ff, d);
                  phase_in = 5'(phase_ff + 5'd1);
               end else failed_in = 1'b1;
            end
            isots_pkg::PH_AFTER_OH: begin
               if (c == isots_pkg::CH_COLON) phase_in = isots_pkg::PH_OM1;
               else if (dig) begin
                  zm_in    = mac7(zm_ff, d);
                  phase_in = isots_pkg::PH_OM2;
               end else if (ws) phase_in = isots_pkg::PH_TRAIL;
               else failed_in = 1'b1;
            end
            isots_pkg::PH_OM1, isots_pkg::PH_OM2: begin
               if (dig) begin
                  zm_in    = mac7(zm_ff, d);
                  phase_in = (phase_ff == isots_pkg::PH_OM2) ? isots_pkg::PH_AFTER_ZONE
                                                              : isots_pkg::PH_OM2;
               end else failed_in = 1'b1;
            end
            default: failed_in = 1'b1;
         endcase
      end
   end

   logic can_end;
   always_comb begin
      unique case (phase_ff) inside
         isots_pkg::PH_AFTER_DATE, isots_pkg::PH_SPACE, isots_pkg::PH_AFTER_MIN,
         isots_pkg::PH_AFTER_SEC, isots_pkg::PH_FRAC, isots_pkg::PH_AFTER_ZONE,
         isots_pkg::PH_AFTER_OH, isots_pkg::PH_TRAIL: can_end = 1'b1;
         default: can_end = 1'b0;
      endcase
   end
   assign sts.fail    = failed_ff;
   assign sts.can_end = can_end;

   // Field limit checks; the century test uses a reciprocal multiply for year / 100.
   logic        leap, range_ok;
   logic [4:0]  mlen;
   logic [22:0] q100_prod;
   logic [6:0]  q100;
   logic        on_century;
   assign q100_prod  = 23'(23'(year_ff[13:2]) * 23'd1311);
   assign q100       = q100_prod[21:15];
   assign on_century = (year_ff == 14'(14'(q100) * 14'd100));
   assign leap = (year_ff[1:0] == 2'b00) && (!on_century || q100[1:0] == 2'b00);
   always_comb begin
      unique case (month_ff) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: mlen = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                    mlen = 5'd30;
         7'd2:    mlen = leap ? 5'd29 : 5'd28;
         default: mlen = 5'd0;
      endcase
   end
   assign range_ok = (mlen != 5'd0) && (day_ff >= 7'd1) && (day_ff <= 7'(mlen)) &&
                     (hour_ff <= 7'd24) && (minute_ff <= 7'd59) && (second_ff <= 7'd60) &&
                     !(hour_ff == 7'd24 && (minute_ff != 7'd0 || second_ff != 7'd0 || fnz_ff)) &&
                     (zh_ff <= 7'd23) && (zm_ff <= 7'd59);

   // Days from civil, computed in stages (year shifted so March opens the year).
   logic signed [14:0] yadj;
   logic [3:0]  mp;
   logic [8:0]  mbase;
   logic [8:0]  doy;
   logic [15:0] era_prod;
   logic signed [5:0] era;
   logic [8:0]  yoe;
   logic [11:0] c100_prod;
   logic [17:0] doe;
   logic [9:0]  frac;
   assign yadj = (month_ff <= 7'd2) ? 15'(signed'({1'b0, year_ff}) - 15'sd1)
                                    : signed'({1'b0, year_ff});
   assign mp   = (month_ff > 7'd2) ? 4'(month_ff - 7'd3) : 4'(month_ff + 7'd9);
   // Days before each month of the March-based year.
   always_comb begin
      unique case (mp)
         4'd1:    mbase = 9'd31;
         4'd2:    mbase = 9'd61;
         4'd3:    mbase = 9'd92;
         4'd4:    mbase = 9'd122;
         4'd5:    mbase = 9'd153;
         4'd6:    mbase = 9'd184;
         4'd7:    mbase = 9'd214;
         4'd8:    mbase = 9'd245;
         4'd9:    mbase = 9'd275;
         4'd10:   mbase = 9'd306;
         4'd11:   mbase = 9'd337;
         default: mbase = 9'd0;
      endcase
   end
   assign doy  = 9'(10'(mbase) + 10'(day_ff) - 10'd1);
   // Years run -1..9999, so the era is -1..24; year / 400 as (year / 16) * 41 / 1024.
   assign era_prod = 16'(16'(yadj[13:4]) * 16'd41);
   assign era  = (yadj < 0) ? -6'sd1 : signed'({1'b0, era_prod[14:10]});
   assign yoe  = 9'(yadj - 15'(era) * 15'sd400);
   // yoe / 100 as (yoe / 4) * 41 / 1024.
   assign c100_prod = 12'(12'(yoe_ff[8:2]) * 12'd41);
   assign doe  = 18'(18'(yoe_ff) * 18'd365 + 18'(yoe_ff[8:2]) - 18'(c100_prod[11:10]) +
                     18'(doy_ff));
   always_comb begin
      case (fcount_ff)
         2'd0:    frac = 10'd0;
         2'd1:    frac = 10'(millis_ff * 10'd100);
         2'd2:    frac = 10'(millis_ff * 10'd10);
         default: frac = millis_ff;
      endcase
   end

   logic signed [48:0] tsum, zone;
   assign tsum = 49'(hour_ff) * 49'sd3600000 + 49'(minute_ff) * 49'sd60000 +
                 49'(second_ff) * 49'sd1000 + 49'(frac);
   assign zone = (49'(zh_ff) * 49'sd60 + 49'(zm_ff)) * 49'sd60000;

   always_ff @(posedge clock) begin
      if (reset || cmd.op == isots_pkg::OP_CLEAR) begin
         phase_ff  <= isots_pkg::PH_LEAD;
         failed_ff <= 1'b0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         millis_ff <= '0;
         fcount_ff <= '0;
         fnz_ff    <= 1'b0;
         zneg_ff   <= 1'b0;
         zh_ff     <= '0;
         zm_ff     <= '0;
         ok_ff     <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         failed_ff <= failed_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         millis_ff <= millis_in;
         fcount_ff <= fcount_in;
         fnz_ff    <= fnz_in;
         zneg_ff   <= zneg_in;
         zh_ff     <= zh_in;
         zm_ff     <= zm_in;
         if (cmd.op == isots_pkg::OP_DATE) ok_ff <= !failed_ff && can_end && range_ok;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         isots_pkg::OP_DATE: begin
            era_ff <= era;
            yoe_ff <= yoe;
            doy_ff <= doy;
         end
         isots_pkg::OP_DAYS:
            days_ff <= 23'(23'(era_ff) * 23'sd146097 + 23'(doe) - 23'sd719468);
         isots_pkg::OP_TIME:
            acc_ff <= 49'(days_ff) * 49'sd86400000;
         isots_pkg::OP_SUM:
            acc_ff <= zneg_ff ? 49'(acc_ff + tsum + zone) : 49'(acc_ff + tsum - zone);
         default: acc_ff <= acc_ff;
      endcase
   end

   assign rsp_parse_ok     = ok_ff;
   assign rsp_epoch_millis = ok_ff ? acc_ff : '0;
endmodule

// ===== design/iso8601_timestamp_parser.sv =====
// Top level of the streaming ISO 8601 timestamp parser.
// Takes one character per cycle while no result is pending; a character without is_last is simply absorbed.
// The final character starts the conversion steps (range check and date split,
// days-from-civil, day-to-millisecond multiply, time and zone sum), after which the
// result is held on rsp_ until taken; no new item is taken meanwhile.
module iso8601_timestamp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_parse_ok,
   output logic signed [48:0] rsp_epoch_millis
);
   isots_pkg::isots_cmd_type cmd;
   isots_pkg::isots_sts_type sts;

   isots_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_char_code(req_char_code), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd)
   );

   isots_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .rsp_parse_ok(rsp_parse_ok), .rsp_epoch_millis(rsp_epoch_millis)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input taken while result pending");
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_parse_ok) |-> (rsp_epoch_millis == '0))
      else $error("nonzero millis on failed parse");
   a_fail_blocks_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == isots_pkg::OP_DATE && sts.fail) |=> !rsp_parse_ok)
      else $error("failed parse reported valid");
`endif
endmodule
